@@ rtl/core/bse_pkg.sv @@
// Package for the bubble sort engine: constants, controller states, command and status types
`default_nettype none
package bse_pkg;

   localparam int VALUE_W       = 32;
   localparam int MAX_ITEMS_DEF = 16;

   typedef enum logic [2:0] {
      S_LOAD,
      S_SORT,
      S_OUT_RD,
      S_OUT_LD,
      S_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic load;
      logic sort_step;
      logic out_read;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_accept;
      logic sort_done;
      logic rsp_done;
      logic rsp_end;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/core/bse_ifs.sv @@
// Request and response channel interfaces of the bubble sort engine
`default_nettype none
interface bse_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bse_pkg::VALUE_W-1:0]   value;
   logic                                 last_item;

   modport source (output valid, value, last_item, input ready);
   modport sink   (input valid, value, last_item, output ready);
endinterface

interface bse_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bse_pkg::VALUE_W-1:0]   sorted_value;
   logic                                 end_of_set;
   logic                                 overflow;

   modport source (output valid, sorted_value, end_of_set, overflow, input ready);
   modport sink   (input valid, sorted_value, end_of_set, overflow, output ready);
endinterface
`default_nettype wire

@@ rtl/core/bse_ram.sv @@
// Generic single write port, single read port RAM with registered read data
`default_nettype none
module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/core/bse_ctrl.sv @@
// Controller state machine of the bubble sort engine: load, sort, output phases
`default_nettype none
module bse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  bse_pkg::stat_type  stat,
   output bse_pkg::cmd_type   cmd
);
   import bse_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (stat.last_accept) begin
               state_in = S_SORT;
            end
         end
         S_SORT: begin
            if (stat.sort_done) begin
               state_in = S_OUT_RD;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            state_in = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (stat.rsp_done) begin
               state_in = stat.rsp_end ? S_LOAD : S_OUT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_LOAD:     cmd.load      = 1'b1;
         S_SORT:     cmd.sort_step = 1'b1;
         S_OUT_RD:   cmd.out_read  = 1'b1;
         S_OUT_LD:   cmd.out_load  = 1'b1;
         S_OUT_WAIT: cmd           = '0;
         default:    cmd           = '0;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/bse_dpath.sv @@
// Datapath of the bubble sort engine: element store, pass sequencing, compare and output register
`default_nettype none
module bse_dpath #(
   parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  bse_pkg::cmd_type   cmd,
   output bse_pkg::stat_type  stat,
   bse_req_if.sink            req_chan,
   bse_rsp_if.source          rsp_chan
);
   import bse_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int IW = $clog2(MAX_ITEMS + 2);

   logic [CW-1:0]             count_ff, count_in;
   logic                      dropped_ff, dropped_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [CW-1:0]             pass_ff, pass_in;
   logic signed [VALUE_W-1:0] held_ff, held_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                      rsp_end_ff, rsp_end_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic                      rd_en;
   logic [VALUE_W-1:0]        rd_raw;
   logic signed [VALUE_W-1:0] rd_data;

   logic                      req_fire;
   logic                      rsp_fire;
   logic                      sort_done;
   logic [IW-1:0]             count_x;
   logic [IW-1:0]             idx_m2;
   logic [CW-1:0]             count_m1;

   bse_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_data   = $signed(rd_raw);
   assign count_x   = IW'(count_ff);
   assign idx_m2    = idx_ff - IW'(2);
   assign count_m1  = count_ff - CW'(1);
   assign req_fire  = cmd.load && req_chan.valid;
   assign rsp_fire  = rsp_valid_ff && rsp_chan.ready;
   assign sort_done = cmd.sort_step && (idx_ff == '0) && (pass_ff >= count_ff);

   always_comb begin
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = req_chan.value;
      rd_en        = 1'b0;

      if (req_fire) begin
         if (count_ff < CW'(MAX_ITEMS)) begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
         if (req_chan.last_item) begin
            idx_in  = '0;
            pass_in = CW'(1);
         end
      end

      // one pass streams the store, carrying the running maximum in held_ff
      if (cmd.sort_step && !sort_done) begin
         if (idx_ff < count_x) begin
            rd_en = 1'b1;
         end
         if (idx_ff == IW'(1)) begin
            held_in = rd_data;
         end else if ((idx_ff >= IW'(2)) && (idx_ff <= count_x)) begin
            wr_en   = 1'b1;
            wr_addr = idx_m2[AW-1:0];
            if (held_ff > rd_data) begin
               wr_data = rd_data;
            end else begin
               wr_data = held_ff;
               held_in = rd_data;
            end
         end
         if (idx_ff == count_x + IW'(1)) begin
            wr_en   = 1'b1;
            wr_addr = count_m1[AW-1:0];
            wr_data = held_ff;
            idx_in  = '0;
            pass_in = pass_ff + CW'(1);
         end else begin
            idx_in = idx_ff + IW'(1);
         end
      end

      if (cmd.out_read) begin
         rd_en = 1'b1;
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = rd_data;
         rsp_end_in   = (idx_ff + IW'(1) == count_x);
         rsp_ovf_in   = dropped_ff;
      end

      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
         if (rsp_end_ff) begin
            idx_in     = '0;
            count_in   = '0;
            dropped_in = 1'b0;
         end else begin
            idx_in = idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         idx_ff       <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         idx_ff       <= idx_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff      <= held_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_chan.ready        = cmd.load;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sorted_value = rsp_value_ff;
   assign rsp_chan.end_of_set   = rsp_end_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;

   assign stat.last_accept = req_fire && req_chan.last_item;
   assign stat.sort_done   = sort_done;
   assign stat.rsp_done    = rsp_fire;
   assign stat.rsp_end     = rsp_end_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("element count beyond capacity");

   a_sort_wr_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.sort_step && wr_en) |-> (CW'(wr_addr) < count_ff))
      else $error("sort pass writes outside the held set");

endmodule
`default_nettype wire

@@ rtl/core/bubble_sort_engine.sv @@
// Bubble sort engine top level: controller and datapath
// Load: one request per cycle; the request marked last starts the sort.
// Sort: n-1 streaming passes over the store's single read port and single write port,
//   for n held elements.
// Output: per response, store read, then response register load, then wait for rsp ready.
// Reset (synchronous, active high) empties the set and clears the flags; store data is kept.
`default_nettype none
module bubble_sort_engine #(
   parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bse_req_if.sink    req_chan,
   bse_rsp_if.source  rsp_chan
);
   import bse_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bse_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   bse_dpath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_chan.valid)
      else $error("request taken while a response is pending");

   a_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.end_of_set) |=> req_chan.ready)
      else $error("not back in load after end of set");

endmodule
`default_nettype wire
